// ----- sv/afcg_pkg.sv -----
package afcg_pkg;

  localparam int SLOT_COUNT = 3;
  localparam int SLOT_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  typedef logic [1:0] req_t;
  localparam req_t REQ_TICK  = 2'd0;
  localparam req_t REQ_SCENE = 2'd1;
  localparam req_t REQ_DONE  = 2'd2;
  localparam req_t REQ_START = 2'd3;

  typedef logic [2:0] action_t;
  localparam action_t ACT_NONE      = 3'd0;
  localparam action_t ACT_DROPPED   = 3'd1;
  localparam action_t ACT_RENDER    = 3'd2;
  localparam action_t ACT_KEEPALIVE = 3'd3;
  localparam action_t ACT_FRAME     = 3'd4;
  localparam action_t ACT_EMPTY     = 3'd5;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_ON_DEMAND = 3'd0;
  localparam cfg_idx_t REG_DEMOTE    = 3'd1;
  localparam cfg_idx_t REG_PROMOTE   = 3'd2;
  localparam cfg_idx_t REG_KEEPALIVE = 3'd3;
  localparam cfg_idx_t REG_BURST     = 3'd4;

  localparam logic [9:0] DEMOTE_RST    = 10'd10;
  localparam logic [9:0] PROMOTE_RST   = 10'd6;
  localparam logic [5:0] KEEPALIVE_RST = 6'd6;
  localparam logic [5:0] BURST_RST     = 6'd6;

  typedef struct packed {
    logic       on_demand;
    logic [9:0] demote_above_ms;
    logic [9:0] promote_below_ms;
    logic [5:0] keepalive_ticks;
    logic [5:0] burst_ticks;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic sum;
    logic decide;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic need_sum;
    logic sum_done;
    logic out_free;
  } stat_t;

endpackage

// ----- sv/afcg_in_if.sv -----
interface afcg_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [9:0] cost_ms;
  logic [1:0] done_slot;
  logic       done_has_data;

  modport source (output valid, output req_type, output cost_ms, output done_slot,
                  output done_has_data, input ready);
  modport sink (input valid, input req_type, input cost_ms, input done_slot,
                input done_has_data, output ready);
endinterface

// ----- sv/afcg_out_if.sv -----
interface afcg_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [1:0] slot;
  logic       rate_is_60;
  logic       rate_changed;
  logic [1:0] in_flight;

  modport source (output valid, output action, output slot, output rate_is_60,
                  output rate_changed, output in_flight, input ready);
  modport sink (input valid, input action, input slot, input rate_is_60,
                input rate_changed, input in_flight, output ready);
endinterface

// ----- sv/afcg_cfg_if.sv -----
interface afcg_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [9:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- sv/afcg_cfg_regs.sv -----
module afcg_cfg_regs
  import afcg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  cfg_idx_t              wr_idx,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.on_demand        <= 1'b0;
      cfg_r.demote_above_ms  <= DEMOTE_RST;
      cfg_r.promote_below_ms <= PROMOTE_RST;
      cfg_r.keepalive_ticks  <= KEEPALIVE_RST;
      cfg_r.burst_ticks      <= BURST_RST;
    end else if (wr_en) begin
      unique case (wr_idx)
        REG_ON_DEMAND: cfg_r.on_demand        <= wr_data[0];
        REG_DEMOTE:    cfg_r.demote_above_ms  <= wr_data[9:0];
        REG_PROMOTE:   cfg_r.promote_below_ms <= wr_data[9:0];
        REG_KEEPALIVE: cfg_r.keepalive_ticks  <= wr_data[5:0];
        REG_BURST:     cfg_r.burst_ticks      <= wr_data[5:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- sv/afcg_ctrl.sv -----
module afcg_ctrl
  import afcg_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SUM  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = stat.need_sum ? S_SUM : S_OUT;
      end
      S_SUM: begin
        cmd.sum = 1'b1;
        if (stat.sum_done) begin
          cmd.decide = 1'b1;
          state_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- sv/afcg_dp.sv -----
module afcg_dp
  import afcg_pkg::*;
#(
  parameter int RING_DEPTH     = 60,
  parameter int DEMOTE_WINDOW  = 30,
  parameter int PROMOTE_WINDOW = 60
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  cmd_t              cmd,
  output stat_t             stat,
  input  logic [1:0]        in_req_type,
  input  logic [9:0]        in_cost_ms,
  input  logic [1:0]        in_done_slot,
  input  logic              in_done_has_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_action,
  output logic [SLOT_W-1:0] out_slot,
  output logic              out_rate_is_60,
  output logic              out_rate_changed,
  output logic [1:0]        out_in_flight
);

  localparam int IDX_W  = $clog2(RING_DEPTH);
  localparam int FILL_W = $clog2(RING_DEPTH + 1);
  localparam int WMAX   = (DEMOTE_WINDOW > PROMOTE_WINDOW) ? DEMOTE_WINDOW : PROMOTE_WINDOW;
  localparam int WIN_W  = $clog2(WMAX + 1);
  localparam int ACC_W  = 10 + WIN_W;
  localparam bit DEM_FITS = DEMOTE_WINDOW <= RING_DEPTH;
  localparam bit PRO_FITS = PROMOTE_WINDOW <= RING_DEPTH;
  localparam logic [FILL_W-1:0] DEM_FILL = FILL_W'(DEM_FITS ? DEMOTE_WINDOW : RING_DEPTH);
  localparam logic [FILL_W-1:0] PRO_FILL = FILL_W'(PRO_FITS ? PROMOTE_WINDOW : RING_DEPTH);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(RING_DEPTH);
  localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(RING_DEPTH - 1);

  // latched item
  req_t        it_req_r;
  logic [9:0]  it_cost_r;
  logic [1:0]  it_dslot_r;
  logic        it_data_r;

  // governor state
  logic [SLOT_COUNT-1:0] busy_r, busy_nxt;
  logic [1:0]            infl_r, infl_nxt;
  logic [5:0]            bud_r, bud_nxt;
  logic [5:0]            idle_r, idle_nxt;
  logic                  cached_r, cached_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [FILL_W-1:0]     fill_r, fill_nxt;
  logic                  at60_r, at60_nxt;
  logic                  run_r, run_nxt;

  // per-item result
  action_t           act_nxt, res_act_r;
  logic [SLOT_W-1:0] slot_nxt, res_slot_r;
  logic              chg_nxt, res_chg_r;
  logic              ring_we;
  logic              chk_dem, chk_pro;
  logic              free_found;
  logic [SLOT_W-1:0] free_slot;
  logic              hit;
  logic [5:0]        idle_inc;

  // window sum
  logic [9:0]       ring_mem [RING_DEPTH];
  logic [9:0]       rdata_r;
  logic [IDX_W-1:0] ptr_r;
  logic [WIN_W-1:0] iss_r;
  logic [WIN_W-1:0] win_r;
  logic             rd_vld_r;
  logic [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] lim_r;
  logic             mode_dem_r;
  logic             issuing;
  logic             fire;

  // output register
  logic              out_valid_r;
  action_t           out_act_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_r60_r;
  logic              out_chg_r;
  logic [1:0]        out_infl_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_req_r   <= in_req_type;
      it_cost_r  <= in_cost_ms;
      it_dslot_r <= in_done_slot;
      it_data_r  <= in_done_has_data;
    end
  end

  assign idle_inc = idle_r + 6'd1;

  always_comb begin
    busy_nxt   = busy_r;
    infl_nxt   = infl_r;
    bud_nxt    = bud_r;
    idle_nxt   = idle_r;
    cached_nxt = cached_r;
    idx_nxt    = idx_r;
    fill_nxt   = fill_r;
    at60_nxt   = at60_r;
    run_nxt    = run_r;
    act_nxt    = ACT_NONE;
    slot_nxt   = '0;
    chg_nxt    = 1'b0;
    ring_we    = 1'b0;
    chk_dem    = 1'b0;
    chk_pro    = 1'b0;
    free_found = 1'b0;
    free_slot  = '0;
    hit        = 1'b0;
    for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
      if (!busy_r[s]) begin
        free_found = 1'b1;
        free_slot  = SLOT_W'(s);
      end
    end
    for (int s = 0; s < SLOT_COUNT; s++) begin
      if (it_dslot_r == SLOT_W'(s) && busy_r[s]) hit = 1'b1;
    end
    unique case (it_req_r)
      REQ_SCENE: bud_nxt = cfg.burst_ticks;
      REQ_DONE: begin
        if (hit) begin
          busy_nxt[it_dslot_r] = 1'b0;
          if (infl_r != 2'd0) infl_nxt = infl_r - 2'd1;
          slot_nxt = it_dslot_r;
          if (it_data_r) begin
            cached_nxt = 1'b1;
            act_nxt    = ACT_FRAME;
          end else begin
            act_nxt = ACT_EMPTY;
          end
        end
      end
      REQ_START: begin
        if (!run_r) begin
          busy_nxt   = '0;
          infl_nxt   = 2'd0;
          bud_nxt    = cfg.burst_ticks;
          idle_nxt   = 6'd0;
          cached_nxt = 1'b0;
          idx_nxt    = '0;
          fill_nxt   = '0;
          at60_nxt   = !cfg.on_demand;
          chg_nxt    = at60_r == cfg.on_demand;
          run_nxt    = 1'b1;
        end
      end
      default: begin
        if (run_r) begin
          priority if (cfg.on_demand && bud_r == 6'd0) begin
            if (cached_r) begin
              if (idle_inc >= cfg.keepalive_ticks) begin
                idle_nxt = 6'd0;
                act_nxt  = ACT_KEEPALIVE;
              end else begin
                idle_nxt = idle_inc;
              end
            end
          end else if (32'(infl_r) >= SLOT_COUNT || !free_found) begin
            act_nxt = ACT_DROPPED;
          end else begin
            if (cfg.on_demand) bud_nxt = bud_r - 6'd1;
            idle_nxt            = 6'd0;
            busy_nxt[free_slot] = 1'b1;
            infl_nxt            = infl_r + 2'd1;
            act_nxt             = ACT_RENDER;
            slot_nxt            = free_slot;
            if (!cfg.on_demand) begin
              ring_we  = 1'b1;
              idx_nxt  = (idx_r == IDX_LAST) ? '0 : idx_r + IDX_W'(1);
              fill_nxt = (fill_r < FILL_MAX) ? fill_r + FILL_W'(1) : fill_r;
              chk_dem  = DEM_FITS && at60_r && fill_nxt >= DEM_FILL;
              chk_pro  = PRO_FITS && !at60_r && fill_nxt >= PRO_FILL;
            end
          end
        end
      end
    endcase
  end

  assign issuing = iss_r != win_r;
  assign fire    = mode_dem_r ? (acc_r >= lim_r) : (acc_r < lim_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= '0;
      infl_r   <= 2'd0;
      bud_r    <= 6'd0;
      idle_r   <= 6'd0;
      cached_r <= 1'b0;
      idx_r    <= '0;
      fill_r   <= '0;
      at60_r   <= 1'b1;
      run_r    <= 1'b0;
    end else if (cmd.exec) begin
      busy_r   <= busy_nxt;
      infl_r   <= infl_nxt;
      bud_r    <= bud_nxt;
      idle_r   <= idle_nxt;
      cached_r <= cached_nxt;
      idx_r    <= idx_nxt;
      fill_r   <= fill_nxt;
      at60_r   <= at60_nxt;
      run_r    <= run_nxt;
    end else if (cmd.decide && fire) begin
      at60_r <= !mode_dem_r;
      idx_r  <= '0;
      fill_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_act_r  <= act_nxt;
      res_slot_r <= slot_nxt;
      res_chg_r  <= chg_nxt;
      mode_dem_r <= chk_dem;
      ptr_r      <= idx_r;
      iss_r      <= '0;
      acc_r      <= '0;
      win_r      <= chk_dem ? WIN_W'(DEMOTE_WINDOW) : WIN_W'(PROMOTE_WINDOW);
      lim_r      <= chk_dem
                    ? ACC_W'((32'(cfg.demote_above_ms) + 32'd1) * 32'(DEMOTE_WINDOW))
                    : ACC_W'(32'(cfg.promote_below_ms) * 32'(PROMOTE_WINDOW));
    end else if (cmd.sum) begin
      if (issuing) begin
        ptr_r <= (ptr_r == '0) ? IDX_LAST : ptr_r - IDX_W'(1);
        iss_r <= iss_r + WIN_W'(1);
      end
      if (rd_vld_r) acc_r <= acc_r + ACC_W'(rdata_r);
      if (cmd.decide && fire) res_chg_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else if (cmd.sum) begin
      rd_vld_r <= issuing;
    end else begin
      rd_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && ring_we) ring_mem[idx_r] <= it_cost_r;
    rdata_r <= ring_mem[ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_act_r  <= res_act_r;
      out_slot_r <= res_slot_r;
      out_r60_r  <= at60_r;
      out_chg_r  <= res_chg_r;
      out_infl_r <= infl_r;
    end
  end

  assign stat.need_sum = chk_dem || chk_pro;
  assign stat.sum_done = !issuing && !rd_vld_r;
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_action       = out_act_r;
  assign out_slot         = out_slot_r;
  assign out_rate_is_60   = out_r60_r;
  assign out_rate_changed = out_chg_r;
  assign out_in_flight    = out_infl_r;

endmodule

// ----- sv/adaptive_frame_cadence_governor_top.sv -----
// Frame cadence governor.
// in_ch  : one event item (tick, scene change, readback completion, start) per handshake.
// out_ch : exactly one result item per input item, in order: action, slot, cadence,
//          cadence-change flag and readbacks outstanding.
// cfg_ch : register writes (index, data), always ready; write only while idle.
// One item is handled at a time. in_ch is ready only when the sequencer is idle.
// Each item is captured, executed and loaded into the output register before the next
// item is accepted. A 60 Hz/30 Hz render that completes an averaging window adds a
// serial sum over the ring memory, one entry per cycle from its single read port,
// before its result is loaded.
// The result sits in an output register; while out_ch.ready is low that item holds,
// the next item is still accepted and processed, then waits in the sequencer with
// in_ch not ready until the output register frees.
// Reset (rst_n low, synchronous) restores the default registers, frees all slots,
// empties the ring fill count, sets 60 Hz and the not-running state. The ring
// memory is not cleared; entries are only read after being written since the last
// start or cadence change.
module adaptive_frame_cadence_governor_top
  import afcg_pkg::*;
#(
  parameter int RING_DEPTH     = 60,
  parameter int DEMOTE_WINDOW  = 30,
  parameter int PROMOTE_WINDOW = 60
) (
  input logic         clk,
  input logic         rst_n,
  afcg_in_if.sink     in_ch,
  afcg_out_if.source  out_ch,
  afcg_cfg_if.sink    cfg_ch
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  assign cfg_ch.ready = 1'b1;

  afcg_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_ch.valid),
    .wr_idx  (cfg_ch.index),
    .wr_data (cfg_ch.data),
    .cfg     (cfg)
  );

  afcg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  afcg_dp #(
    .RING_DEPTH     (RING_DEPTH),
    .DEMOTE_WINDOW  (DEMOTE_WINDOW),
    .PROMOTE_WINDOW (PROMOTE_WINDOW)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .stat             (stat),
    .in_req_type      (in_ch.req_type),
    .in_cost_ms       (in_ch.cost_ms),
    .in_done_slot     (in_ch.done_slot),
    .in_done_has_data (in_ch.done_has_data),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_action       (out_ch.action),
    .out_slot         (out_ch.slot),
    .out_rate_is_60   (out_ch.rate_is_60),
    .out_rate_changed (out_ch.rate_changed),
    .out_in_flight    (out_ch.in_flight)
  );

endmodule

// ----- tb/adaptive_frame_cadence_governor_top_tb.sv -----
module adaptive_frame_cadence_governor_top_tb;
  import afcg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH     = 60;
  localparam int DEMOTE_WINDOW  = 30;
  localparam int PROMOTE_WINDOW = 60;
  localparam int CYCLE_LIMIT    = 1_000_000;

  typedef struct {
    req_t       req;
    logic [9:0] cost;
    logic [1:0] dslot;
    logic       ddata;
    bit         settle;  // hold until every outstanding result is back
  } request_t;

  typedef struct {
    action_t    action;
    logic [1:0] slot;
    logic       rate_is_60;
    logic       rate_changed;
    logic [1:0] in_flight;
  } outcome_t;

  logic clk;
  logic rst_n;

  afcg_in_if  in_ch ();
  afcg_out_if out_ch ();
  afcg_cfg_if cfg_ch ();

  adaptive_frame_cadence_governor_top #(
    .RING_DEPTH    (RING_DEPTH),
    .DEMOTE_WINDOW (DEMOTE_WINDOW),
    .PROMOTE_WINDOW(PROMOTE_WINDOW)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // governor shadow state
  cfg_t                  gov_cfg;
  logic [SLOT_COUNT-1:0] busy;
  int                    inflight;
  logic [5:0]            budget;
  logic [5:0]            idle;
  logic                  cached;
  logic [9:0]            ring [RING_DEPTH];
  int                    ring_idx;
  int                    ring_fill;
  logic                  sixty;
  logic                  running;

  request_t request_q[$];
  outcome_t outcome_q[$];
  request_t cur_req;

  int  errors;
  int  cycles;
  int  gap_left;
  int  stall_left;
  bit  quiet;
  int  seg_left;
  bit  seg_high;
  int  n_accepted, n_render, n_drop, n_keep, n_frame, n_empty, n_change;

  function automatic void reset_governor();
    gov_cfg = '{1'b0, DEMOTE_RST, PROMOTE_RST, KEEPALIVE_RST, BURST_RST};
    busy = '0;
    inflight = 0;
    budget = '0;
    idle = '0;
    cached = 1'b0;
    foreach (ring[i]) ring[i] = '0;
    ring_idx = 0;
    ring_fill = 0;
    sixty = 1'b1;
    running = 1'b0;
  endfunction

  function automatic int window_mean(int n);
    int total;
    total = 0;
    for (int i = 0; i < n; i++)
      total += int'(ring[(ring_idx + 2 * RING_DEPTH - 1 - i) % RING_DEPTH]);
    return total / n;
  endfunction

  function automatic outcome_t govern(request_t r);
    outcome_t o;
    int       found;
    o = '{ACT_NONE, 2'd0, 1'b0, 1'b0, 2'd0};
    case (r.req)
      REQ_SCENE: budget = gov_cfg.burst_ticks;
      REQ_DONE: begin
        if (r.dslot < SLOT_COUNT && busy[r.dslot]) begin
          busy[r.dslot] = 1'b0;
          if (inflight > 0) inflight--;
          o.slot = r.dslot;
          if (r.ddata) begin
            cached = 1'b1;
            o.action = ACT_FRAME;
          end else begin
            o.action = ACT_EMPTY;
          end
        end
      end
      REQ_START: begin
        if (!running) begin
          busy = '0;
          inflight = 0;
          budget = gov_cfg.burst_ticks;
          idle = '0;
          cached = 1'b0;
          foreach (ring[i]) ring[i] = '0;
          ring_idx = 0;
          ring_fill = 0;
          if (sixty != !gov_cfg.on_demand) begin
            sixty = !gov_cfg.on_demand;
            o.rate_changed = 1'b1;
          end
          running = 1'b1;
        end
      end
      default: begin
        if (running) begin
          if (gov_cfg.on_demand && budget == 0) begin
            if (cached) begin
              idle = idle + 6'd1;
              if (idle >= gov_cfg.keepalive_ticks) begin
                idle = '0;
                o.action = ACT_KEEPALIVE;
              end
            end
          end else if (inflight >= SLOT_COUNT) begin
            o.action = ACT_DROPPED;
          end else begin
            found = SLOT_COUNT;
            for (int i = SLOT_COUNT - 1; i >= 0; i--)
              if (!busy[i]) found = i;
            if (found == SLOT_COUNT) begin
              o.action = ACT_DROPPED;
            end else begin
              if (gov_cfg.on_demand) budget = budget - 6'd1;
              idle = '0;
              busy[found] = 1'b1;
              inflight++;
              o.action = ACT_RENDER;
              o.slot = found[1:0];
              if (!gov_cfg.on_demand) begin
                ring[ring_idx] = r.cost;
                ring_idx = (ring_idx + 1) % RING_DEPTH;
                if (ring_fill < RING_DEPTH) ring_fill++;
                if (sixty && ring_fill >= DEMOTE_WINDOW) begin
                  if (window_mean(DEMOTE_WINDOW) > int'(gov_cfg.demote_above_ms)) begin
                    sixty = 1'b0;
                    o.rate_changed = 1'b1;
                    ring_fill = 0;
                    ring_idx = 0;
                  end
                end else if (!sixty && ring_fill >= PROMOTE_WINDOW) begin
                  if (window_mean(PROMOTE_WINDOW) < int'(gov_cfg.promote_below_ms)) begin
                    sixty = 1'b1;
                    o.rate_changed = 1'b1;
                    ring_fill = 0;
                    ring_idx = 0;
                  end
                end
              end
            end
          end
        end
      end
    endcase
    o.rate_is_60 = sixty;
    o.in_flight = inflight[1:0];
    case (o.action)
      ACT_RENDER:    n_render++;
      ACT_DROPPED:   n_drop++;
      ACT_KEEPALIVE: n_keep++;
      ACT_FRAME:     n_frame++;
      ACT_EMPTY:     n_empty++;
      default: ;
    endcase
    if (o.rate_changed) n_change++;
    return o;
  endfunction

  function automatic void push_req(req_t req, logic [9:0] cost, logic [1:0] dslot,
                                   logic ddata);
    request_q.push_back('{req, cost, dslot, ddata, 1'b0});
  endfunction

  function automatic request_t random_request(cfg_t c);
    request_t r;
    int       pick;
    int       lo, hi;
    pick = $urandom_range(0, 99);
    r.req = pick < 55 ? REQ_TICK : pick < 90 ? REQ_DONE : pick < 98 ? REQ_SCENE : REQ_START;
    if (seg_left == 0) begin
      seg_high = !seg_high;
      seg_left = $urandom_range(80, 200);
    end
    seg_left--;
    if ($urandom_range(0, 11) == 0) begin
      r.cost = 10'($urandom_range(0, 1023));
    end else if (seg_high) begin
      lo = c.demote_above_ms < 1023 ? int'(c.demote_above_ms) + 1 : 1023;
      hi = 2 * int'(c.demote_above_ms) + 40;
      if (hi > 1023) hi = 1023;
      if (hi < lo) hi = lo;
      r.cost = 10'($urandom_range(hi, lo));
    end else begin
      r.cost = c.promote_below_ms == 0 ? 10'd0
             : 10'($urandom_range(int'(c.promote_below_ms) - 1, 0));
    end
    r.dslot = $urandom_range(0, 15) == 0 ? 2'd3 : 2'($urandom_range(0, 2));
    r.ddata = 1'($urandom_range(0, 1));
    r.settle = $urandom_range(0, 99) == 0;
    return r;
  endfunction

  task automatic wait_idle();
    @(negedge clk);
    while (request_q.size() != 0 || outcome_q.size() != 0 || in_ch.valid)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_config(cfg_t c);
    cfg_idx_t   regs [5];
    logic [9:0] vals [5];
    regs = '{REG_ON_DEMAND, REG_DEMOTE, REG_PROMOTE, REG_KEEPALIVE, REG_BURST};
    vals = '{{9'd0, c.on_demand}, c.demote_above_ms, c.promote_below_ms,
             {4'd0, c.keepalive_ticks}, {4'd0, c.burst_ticks}};
    for (int i = 0; i < 5; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= regs[i];
      cfg_ch.data  <= vals[i];
      do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    end
    cfg_ch.valid <= 1'b0;
    gov_cfg = c;
  endtask

  task automatic run_phase(cfg_t c, int n);
    request_t r;
    wait_idle();
    load_config(c);
    for (int i = 0; i < n; i++) begin
      r = random_request(c);
      if (i == 100) r.settle = 1'b1;
      request_q.push_back(r);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        outcome_q.push_back(govern(cur_req));
        n_accepted++;
        if (!quiet && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 4);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (request_q.size() != 0 &&
                     !(request_q[0].settle && outcome_q.size() != 0)) begin
          cur_req = request_q.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.req_type      <= cur_req.req;
          in_ch.cost_ms       <= cur_req.cost;
          in_ch.done_slot     <= cur_req.dslot;
          in_ch.done_has_data <= cur_req.ddata;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    outcome_t o;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (outcome_q.size() == 0) begin
          $error("result item with none expected");
          errors++;
        end else begin
          o = outcome_q.pop_front();
          if (out_ch.action !== o.action) begin
            $error("action expected %0d got %0d", o.action, out_ch.action);
            errors++;
          end
          if (out_ch.slot !== o.slot) begin
            $error("slot expected %0d got %0d", o.slot, out_ch.slot);
            errors++;
          end
          if (out_ch.rate_is_60 !== o.rate_is_60) begin
            $error("rate_is_60 expected %0d got %0d", o.rate_is_60, out_ch.rate_is_60);
            errors++;
          end
          if (out_ch.rate_changed !== o.rate_changed) begin
            $error("rate_changed expected %0d got %0d", o.rate_changed, out_ch.rate_changed);
            errors++;
          end
          if (out_ch.in_flight !== o.in_flight) begin
            $error("in_flight expected %0d got %0d", o.in_flight, out_ch.in_flight);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[adaptive_frame_cadence_governor_top] ERROR");
      $finish;
    end
  end

  initial begin
    cfg_t c;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_TICK;
    in_ch.cost_ms = '0;
    in_ch.done_slot = '0;
    in_ch.done_has_data = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_ON_DEMAND;
    cfg_ch.data = '0;
    reset_governor();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // not running yet: tick, stray completion, scene change
    push_req(REQ_TICK, 10'd1023, 2'd0, 1'b0);
    push_req(REQ_DONE, 10'd0, 2'd0, 1'b1);
    push_req(REQ_SCENE, 10'd0, 2'd0, 1'b0);
    wait_idle();
    load_config('{1'b1, 10'd10, 10'd6, 6'd2, 6'd2});
    // on-demand start drops to 30 Hz, second start is a no-op
    push_req(REQ_START, 10'd0, 2'd0, 1'b0);
    push_req(REQ_START, 10'd0, 2'd0, 1'b0);
    push_req(REQ_TICK, 10'd0, 2'd0, 1'b0);
    push_req(REQ_TICK, 10'd1023, 2'd0, 1'b0);
    push_req(REQ_TICK, 10'd5, 2'd0, 1'b0);      // budget spent, no cached frame
    push_req(REQ_DONE, 10'd0, 2'd3, 1'b1);      // slot out of range
    push_req(REQ_DONE, 10'd0, 2'd2, 1'b1);      // free slot
    push_req(REQ_DONE, 10'd0, 2'd1, 1'b1);
    push_req(REQ_TICK, 10'd5, 2'd0, 1'b0);
    push_req(REQ_TICK, 10'd5, 2'd0, 1'b0);      // keepalive resend
    push_req(REQ_DONE, 10'd0, 2'd0, 1'b0);      // empty completion
    push_req(REQ_SCENE, 10'd0, 2'd0, 1'b0);
    push_req(REQ_TICK, 10'd7, 2'd0, 1'b0);
    push_req(REQ_TICK, 10'd8, 2'd0, 1'b0);
    push_req(REQ_TICK, 10'd9, 2'd0, 1'b0);
    wait_idle();
    load_config('{1'b0, 10'd10, 10'd6, 6'd6, 6'd6});
    push_req(REQ_TICK, 10'd512, 2'd0, 1'b0);
    push_req(REQ_TICK, 10'd3, 2'd0, 1'b0);      // all slots busy
    push_req(REQ_DONE, 10'd0, 2'd2, 1'b1);
    push_req(REQ_DONE, 10'd0, 2'd0, 1'b0);
    push_req(REQ_DONE, 10'd0, 2'd1, 1'b1);

    run_phase('{1'b1, 10'd10, 10'd6, 6'd3, 6'd4}, 250);
    run_phase('{1'b0, 10'd10, 10'd6, 6'd6, 6'd6}, 300);
    run_phase('{1'b0, 10'd0, 10'd1023, 6'd1, 6'd1}, 250);
    run_phase('{1'b0, 10'd1023, 10'd0, 6'd63, 6'd63}, 200);
    run_phase('{1'b1, 10'd40, 10'd20, 6'd1, 6'd63}, 200);
    run_phase('{1'b1, 10'd200, 10'd100, 6'd63, 6'd1}, 150);
    c.on_demand = 1'($urandom_range(0, 1));
    c.demote_above_ms = 10'($urandom_range(300, 5));
    c.promote_below_ms = 10'($urandom_range(int'(c.demote_above_ms), 0));
    c.keepalive_ticks = 6'($urandom_range(63, 1));
    c.burst_ticks = 6'($urandom_range(63, 1));
    run_phase(c, 200);
    wait_idle();
    quiet = 1'b1;
    c.on_demand = 1'b0;
    c.demote_above_ms = 10'($urandom_range(300, 5));
    c.promote_below_ms = 10'($urandom_range(int'(c.demote_above_ms), 0));
    run_phase(c, 150);

    wait_idle();
    repeat (100) @(posedge clk);
    $display("run: %0d requests, %0d renders, %0d drops, %0d keepalive resends",
             n_accepted, n_render, n_drop, n_keep);
    $display("     %0d frame completions, %0d empty completions, %0d cadence changes",
             n_frame, n_empty, n_change);
    if (errors == 0) begin
      $display("[adaptive_frame_cadence_governor_top] OK");
    end else begin
      $display("[adaptive_frame_cadence_governor_top] ERROR");
    end
    $finish;
  end

endmodule

// ----- adaptive_frame_cadence_governor_top.f -----
sv/afcg_pkg.sv
sv/afcg_in_if.sv
sv/afcg_out_if.sv
sv/afcg_cfg_if.sv
sv/afcg_cfg_regs.sv
sv/afcg_ctrl.sv
sv/afcg_dp.sv
sv/adaptive_frame_cadence_governor_top.sv
tb/adaptive_frame_cadence_governor_top_tb.sv
